@@ rtl/core/rps_pkg.sv @@
// ----------------------------------------------------------------------------
// Replica placement selector package
// Shared types and codes for the node table cells and the control logic.
// ----------------------------------------------------------------------------
package rps_pkg;

   localparam int IdWidth     = 16;
   localparam int WeightWidth = 31;
   localparam int SpaceWidth  = 48;
   localparam int LimitWidth  = 8;
   localparam int CopiesWidth = 4;
   localparam int SlotWidth   = 6;
   localparam int PickWidth   = 5;

   // Request kinds as they arrive on the request channel.
   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_PING   = 2'd1,
      KIND_ERROR  = 2'd2,
      KIND_SELECT = 2'd3
   } req_kind_type;

   // Operation broadcast to every cell in the same cycle.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_PING,
      OP_ERROR,
      OP_CLEAR,
      OP_SCAN,
      OP_PICK,
      OP_TAKE
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_PICK,
      ST_EMIT,
      ST_FAIL
   } state_type;

   typedef struct packed {
      cell_op_type            op;
      logic [IdWidth-1:0]     node_id;
      logic [IdWidth-1:0]     group_id;
      logic                   active;
      logic                   can_put;
      logic                   down;
      logic [WeightWidth-1:0] weight;
      logic [SpaceWidth-1:0]  space;
      logic [LimitWidth-1:0]  limit;
      logic                   fire;
   } bus_type;

   // Running minimum handed from cell to cell during a pick pass.
   typedef struct packed {
      logic                   valid;
      logic [WeightWidth-1:0] weight;
      logic [IdWidth-1:0]     id;
   } link_type;

endpackage

@@ rtl/core/rps_cell.sv @@
// ----------------------------------------------------------------------------
// Replica placement selector cell
// Holds one table slot and one stage of the minimum-weight chain.
// ----------------------------------------------------------------------------
module rps_cell #(
   parameter int IDX_W = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 sel,
   input  rps_pkg::bus_type     bus,
   input  logic [IDX_W-1:0]     my_index,
   input  rps_pkg::link_type    link_in,
   input  logic [IDX_W-1:0]     idx_in,
   output rps_pkg::link_type    link_out,
   output logic [IDX_W-1:0]     idx_out,
   output logic                 fire,
   output logic [rps_pkg::IdWidth-1:0] group
);

   logic                                valid_ff;
   logic                                cand_ff;
   logic                                killed_ff;
   logic [rps_pkg::IdWidth-1:0]         id_ff;
   logic [rps_pkg::IdWidth-1:0]         group_ff;
   logic                                active_ff;
   logic                                can_put_ff;
   logic                                down_ff;
   logic [rps_pkg::WeightWidth-1:0]     weight_ff;
   logic [rps_pkg::SpaceWidth-1:0]      free_ff;
   logic [rps_pkg::LimitWidth-1:0]      errs_ff;
   rps_pkg::link_type                   link_ff;
   logic [IDX_W-1:0]                    idx_ff;
   logic                                elig;
   logic                                take_own;

   assign elig = valid_ff && active_ff && can_put_ff && !down_ff && (bus.space < free_ff);
   assign fire = elig && !killed_ff;
   assign group = group_ff;
   assign take_own = cand_ff && (!link_in.valid || (weight_ff < link_in.weight));
   assign link_out = link_ff;
   assign idx_out = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cand_ff <= 1'b0;
         killed_ff <= 1'b0;
      end else begin
         case (bus.op)
            rps_pkg::OP_LOAD: begin
               if (sel) valid_ff <= 1'b1;
            end
            rps_pkg::OP_CLEAR: begin
               cand_ff <= 1'b0;
               killed_ff <= 1'b0;
            end
            rps_pkg::OP_SCAN: begin
               if (sel) cand_ff <= fire;
               if (bus.fire && (bus.group_id == group_ff)) killed_ff <= 1'b1;
            end
            rps_pkg::OP_TAKE: begin
               if (sel) cand_ff <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (bus.op)
         rps_pkg::OP_LOAD: begin
            if (sel) begin
               id_ff <= bus.node_id;
               group_ff <= bus.group_id;
               active_ff <= bus.active;
               can_put_ff <= bus.can_put;
               down_ff <= bus.down;
               weight_ff <= bus.weight;
               free_ff <= '0;
               errs_ff <= '0;
            end
         end
         rps_pkg::OP_PING: begin
            if (sel && valid_ff) begin
               free_ff <= bus.space;
               errs_ff <= '0;
               down_ff <= 1'b0;
            end
         end
         rps_pkg::OP_ERROR: begin
            if (sel && valid_ff) begin
               if (errs_ff >= bus.limit) down_ff <= 1'b1;
               else errs_ff <= errs_ff + 1'b1;
            end
         end
         rps_pkg::OP_PICK: begin
            if (take_own) begin
               link_ff.valid <= 1'b1;
               link_ff.weight <= weight_ff;
               link_ff.id <= id_ff;
               idx_ff <= my_index;
            end else begin
               link_ff <= link_in;
               idx_ff <= idx_in;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

@@ rtl/core/replica_placement_selector_top.sv @@
// ----------------------------------------------------------------------------
// Replica placement selector
// Node table built as a row of slot cells with a sequencer for selection.
// ----------------------------------------------------------------------------
// Load, ping and error requests produce no response.
// A select request first scans the slots, one per cycle: each step decides
// whether the slot is a candidate and knocks out later slots of the same
// group. It then runs one pick pass per requested copy; a pass pushes the
// running minimum weight through the row of cells, one cell per cycle, and
// then hands the winner to the response register once that register is
// free. A select that fails gives one response after the scan, through the
// decide and fail states. The response register decouples the response
// side, so the block takes new requests while a response waits.
module replica_placement_selector_top #(
   parameter int NODES      = 64,
   parameter int MAX_COPIES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rps_pkg::LimitWidth-1:0]     csr_error_limit,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_kind,
   input  logic [rps_pkg::SlotWidth-1:0]      req_slot,
   input  logic [rps_pkg::IdWidth-1:0]        req_node_id,
   input  logic [rps_pkg::IdWidth-1:0]        req_group_id,
   input  logic                               req_active,
   input  logic                               req_can_put,
   input  logic                               req_down,
   input  logic [rps_pkg::WeightWidth-1:0]    req_weight,
   input  logic [rps_pkg::SpaceWidth-1:0]     req_left_space,
   input  logic [rps_pkg::CopiesWidth-1:0]    req_copies,
   input  logic [rps_pkg::SpaceWidth-1:0]     req_min_space,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rps_pkg::IdWidth-1:0]        rsp_chosen_id,
   output logic                               rsp_found,
   output logic                               rsp_last
);

   localparam int IDX_W = $clog2(NODES);
   localparam int CNT_W = $clog2(NODES + 1);
   localparam int AW    = (IDX_W > rps_pkg::SlotWidth) ? IDX_W : rps_pkg::SlotWidth;

   rps_pkg::state_type                  state_ff, state_in;
   logic [IDX_W-1:0]                    cnt_ff, cnt_in;
   logic [CNT_W-1:0]                    groups_ff, groups_in;
   logic [rps_pkg::PickWidth-1:0]       pick_ff, pick_in;
   logic [rps_pkg::CopiesWidth-1:0]     copies_ff, copies_in;
   logic [rps_pkg::SpaceWidth-1:0]      space_ff, space_in;
   logic [rps_pkg::LimitWidth-1:0]      limit_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [rps_pkg::IdWidth-1:0]         rsp_id_ff, rsp_id_in;
   logic                                rsp_found_ff, rsp_found_in;
   logic                                rsp_last_ff, rsp_last_in;

   rps_pkg::bus_type                    bus;
   logic [AW-1:0]                       sel_addr;
   logic [NODES-1:0]                    sel;
   logic [NODES-1:0]                    fire;
   logic [rps_pkg::IdWidth-1:0]         group [NODES];
   rps_pkg::link_type                   link [NODES+1];
   logic [IDX_W-1:0]                    idx [NODES+1];
   logic                                out_free;
   logic                                is_last;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != rps_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_chosen_id = rsp_id_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_last = rsp_last_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_last = ((pick_ff + 1'b1) == {1'b0, copies_ff});

   // The head of the chain always sees an empty running minimum.
   assign link[0] = '0;
   assign idx[0] = '0;

   for (genvar i = 0; i < NODES; i++) begin : g_cell
      assign sel[i] = (sel_addr == AW'(i));
      rps_cell #(.IDX_W(IDX_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .sel      (sel[i]),
         .bus      (bus),
         .my_index (IDX_W'(i)),
         .link_in  (link[i]),
         .idx_in   (idx[i]),
         .link_out (link[i+1]),
         .idx_out  (idx[i+1]),
         .fire     (fire[i]),
         .group    (group[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      groups_in = groups_ff;
      pick_in = pick_ff;
      copies_in = copies_ff;
      space_in = space_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_id_in = rsp_id_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in = rsp_last_ff;
      sel_addr = AW'(cnt_ff);

      bus.op = rps_pkg::OP_NONE;
      bus.node_id = req_node_id;
      bus.group_id = req_group_id;
      bus.active = req_active;
      bus.can_put = req_can_put;
      bus.down = req_down;
      bus.weight = req_weight;
      bus.space = space_ff;
      bus.limit = limit_ff;
      bus.fire = 1'b0;

      case (state_ff)
         rps_pkg::ST_IDLE: begin
            sel_addr = AW'(req_slot);
            bus.space = req_left_space;
            if (req_valid) begin
               case (rps_pkg::req_kind_type'(req_kind))
                  rps_pkg::KIND_LOAD: bus.op = rps_pkg::OP_LOAD;
                  rps_pkg::KIND_PING: bus.op = rps_pkg::OP_PING;
                  rps_pkg::KIND_ERROR: bus.op = rps_pkg::OP_ERROR;
                  rps_pkg::KIND_SELECT: begin
                     bus.op = rps_pkg::OP_CLEAR;
                     copies_in = req_copies;
                     space_in = req_min_space;
                     cnt_in = '0;
                     groups_in = '0;
                     pick_in = '0;
                     state_in = rps_pkg::ST_SCAN;
                  end
                  default: bus.op = rps_pkg::OP_NONE;
               endcase
            end
         end
         rps_pkg::ST_SCAN: begin
            // The slot under the scan pointer, if it fires, becomes a candidate and
            // claims its group against all later slots in the same cycle.
            bus.op = rps_pkg::OP_SCAN;
            bus.fire = fire[cnt_ff];
            bus.group_id = group[cnt_ff];
            if (fire[cnt_ff]) groups_in = groups_ff + 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(NODES - 1)) begin
               cnt_in = '0;
               state_in = rps_pkg::ST_DECIDE;
            end
         end
         rps_pkg::ST_DECIDE: begin
            if ((32'(copies_ff) > MAX_COPIES) || (32'(groups_ff) < 32'(copies_ff))) begin
               state_in = rps_pkg::ST_FAIL;
            end else if (copies_ff == '0) begin
               state_in = rps_pkg::ST_IDLE;
            end else begin
               state_in = rps_pkg::ST_PICK;
            end
         end
         rps_pkg::ST_PICK: begin
            bus.op = rps_pkg::OP_PICK;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(NODES - 1)) begin
               cnt_in = '0;
               state_in = rps_pkg::ST_EMIT;
            end
         end
         rps_pkg::ST_EMIT: begin
            sel_addr = AW'(idx[NODES]);
            if (out_free) begin
               bus.op = rps_pkg::OP_TAKE;
               rsp_valid_in = 1'b1;
               rsp_id_in = link[NODES].id;
               rsp_found_in = 1'b1;
               rsp_last_in = is_last;
               pick_in = pick_ff + 1'b1;
               state_in = is_last ? rps_pkg::ST_IDLE : rps_pkg::ST_PICK;
            end
         end
         rps_pkg::ST_FAIL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in = '0;
               rsp_found_in = 1'b0;
               rsp_last_in = 1'b1;
               state_in = rps_pkg::ST_IDLE;
            end
         end
         default: state_in = rps_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rps_pkg::ST_IDLE;
         limit_ff <= rps_pkg::LimitWidth'(3);
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
         groups_ff <= '0;
         pick_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
         groups_ff <= groups_in;
         pick_ff <= pick_in;
         if (csr_valid) limit_ff <= csr_error_limit;
      end
   end

   always_ff @(posedge clock) begin
      copies_ff <= copies_in;
      space_ff <= space_in;
      rsp_id_ff <= rsp_id_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

@@ dv/tb_replica_placement_selector_top.sv @@
// ----------------------------------------------------------------------------
// Replica placement selector testbench
// Drives load, ping, error and select requests through the request channel,
// predicts the node choices of every select from a private copy of the node
// table, and checks each response field by field under varied idling.
// ----------------------------------------------------------------------------
module tb_replica_placement_selector_top;

   localparam int NodeCount  = 64;
   localparam int CopiesMax  = 8;
   // Idle time after a drain that covers a select that gives no response
   // before the limit is rewritten.
   localparam int DrainCycles = 700;

   typedef struct {
      rps_pkg::req_kind_type                 kind;
      logic [rps_pkg::SlotWidth-1:0]         slot;
      logic [rps_pkg::IdWidth-1:0]           node_id;
      logic [rps_pkg::IdWidth-1:0]           group_id;
      logic                                  active;
      logic                                  can_put;
      logic                                  down;
      logic [rps_pkg::WeightWidth-1:0]       weight;
      logic [rps_pkg::SpaceWidth-1:0]        left_space;
      logic [rps_pkg::CopiesWidth-1:0]       copies;
      logic [rps_pkg::SpaceWidth-1:0]        min_space;
   } node_req_type;

   typedef struct {
      logic [rps_pkg::IdWidth-1:0] chosen_id;
      logic                        found;
      logic                        last;
   } pick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [rps_pkg::LimitWidth-1:0]    csr_error_limit = '0;

   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [1:0]                        req_kind = '0;
   logic [rps_pkg::SlotWidth-1:0]     req_slot = '0;
   logic [rps_pkg::IdWidth-1:0]       req_node_id = '0;
   logic [rps_pkg::IdWidth-1:0]       req_group_id = '0;
   logic                              req_active = 1'b0;
   logic                              req_can_put = 1'b0;
   logic                              req_down = 1'b0;
   logic [rps_pkg::WeightWidth-1:0]   req_weight = '0;
   logic [rps_pkg::SpaceWidth-1:0]    req_left_space = '0;
   logic [rps_pkg::CopiesWidth-1:0]   req_copies = '0;
   logic [rps_pkg::SpaceWidth-1:0]    req_min_space = '0;

   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [rps_pkg::IdWidth-1:0]       rsp_chosen_id;
   logic                              rsp_found;
   logic                              rsp_last;

   // Requests waiting to be driven, and the node choices still owed by the block.
   node_req_type req_backlog[$];
   pick_type     pending_picks[$];
   int           failures = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   logic         req_taken = 1'b0;

   // Private copy of the node table and the error limit.
   bit                                tbl_valid[NodeCount];
   logic [rps_pkg::IdWidth-1:0]       tbl_id[NodeCount];
   logic [rps_pkg::IdWidth-1:0]       tbl_group[NodeCount];
   bit                                tbl_active[NodeCount];
   bit                                tbl_can_put[NodeCount];
   bit                                tbl_down[NodeCount];
   logic [rps_pkg::SpaceWidth-1:0]    tbl_space[NodeCount];
   logic [rps_pkg::WeightWidth-1:0]   tbl_weight[NodeCount];
   logic [rps_pkg::LimitWidth-1:0]    tbl_errors[NodeCount];
   logic [rps_pkg::LimitWidth-1:0]    err_limit = 8'd3;

   replica_placement_selector_top u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_error_limit (csr_error_limit),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_slot        (req_slot),
      .req_node_id     (req_node_id),
      .req_group_id    (req_group_id),
      .req_active      (req_active),
      .req_can_put     (req_can_put),
      .req_down        (req_down),
      .req_weight      (req_weight),
      .req_left_space  (req_left_space),
      .req_copies      (req_copies),
      .req_min_space   (req_min_space),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_chosen_id   (rsp_chosen_id),
      .rsp_found       (rsp_found),
      .rsp_last        (rsp_last)
   );

   always #5 clock = ~clock;

   // Works out which nodes a select picks. Slots are scanned in ascending
   // order and only the first eligible node of each group survives; then the
   // lowest weights are taken one at a time, ties going to the lower slot.
   function automatic void predict_select(logic [rps_pkg::CopiesWidth-1:0] copies,
                                          logic [rps_pkg::SpaceWidth-1:0] need);
      bit       cand[NodeCount];
      int       count;
      int       best;
      bit       fresh;
      pick_type pick;
      count = 0;
      for (int s = 0; s < NodeCount; s++) begin
         cand[s] = 1'b0;
         if (tbl_valid[s] && tbl_active[s] && tbl_can_put[s] && !tbl_down[s] &&
             need < tbl_space[s]) begin
            fresh = 1'b1;
            for (int t = 0; t < s; t++)
               if (cand[t] && tbl_group[t] == tbl_group[s]) fresh = 1'b0;
            if (fresh) begin
               cand[s] = 1'b1;
               count++;
            end
         end
      end
      if (copies > CopiesMax || count < copies) begin
         pick.chosen_id = '0;
         pick.found = 1'b0;
         pick.last = 1'b1;
         pending_picks.insert(pending_picks.size(), pick);
         return;
      end
      // Zero copies falls straight through and owes no response.
      for (int k = 0; k < copies; k++) begin
         best = -1;
         for (int s = 0; s < NodeCount; s++)
            if (cand[s] && (best < 0 || tbl_weight[s] < tbl_weight[best])) best = s;
         cand[best] = 1'b0;
         pick.chosen_id = tbl_id[best];
         pick.found = 1'b1;
         pick.last = (k + 1 == copies);
         pending_picks.insert(pending_picks.size(), pick);
      end
   endfunction

   // Updates the table copy for one accepted request.
   function automatic void track_request(node_req_type r);
      int s;
      s = int'(r.slot);
      case (r.kind)
         rps_pkg::KIND_LOAD: begin
            tbl_valid[s] = 1'b1;
            tbl_id[s] = r.node_id;
            tbl_group[s] = r.group_id;
            tbl_active[s] = r.active;
            tbl_can_put[s] = r.can_put;
            tbl_down[s] = r.down;
            tbl_weight[s] = r.weight;
            tbl_space[s] = '0;
            tbl_errors[s] = '0;
         end
         rps_pkg::KIND_PING: begin
            if (tbl_valid[s]) begin
               tbl_space[s] = r.left_space;
               tbl_errors[s] = '0;
               tbl_down[s] = 1'b0;
            end
         end
         rps_pkg::KIND_ERROR: begin
            if (tbl_valid[s]) begin
               if (tbl_errors[s] >= err_limit) tbl_down[s] = 1'b1;
               else tbl_errors[s] = tbl_errors[s] + 1'b1;
            end
         end
         default: predict_select(r.copies, r.min_space);
      endcase
   endfunction

   // Request driver. A new request goes out only once the current one has
   // been taken, so a stalled payload never moves.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            node_req_type r;
            r = req_backlog.pop_front();
            req_valid <= 1'b1;
            req_kind <= r.kind;
            req_slot <= r.slot;
            req_node_id <= r.node_id;
            req_group_id <= r.group_id;
            req_active <= r.active;
            req_can_put <= r.can_put;
            req_down <= r.down;
            req_weight <= r.weight;
            req_left_space <= r.left_space;
            req_copies <= r.copies;
            req_min_space <= r.min_space;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Acceptance of requests: the predictor sees each one as the block does.
   always @(posedge clock) begin
      node_req_type r;
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset && req_valid && !req_stall) begin
         r.kind = rps_pkg::req_kind_type'(req_kind);
         r.slot = req_slot;
         r.node_id = req_node_id;
         r.group_id = req_group_id;
         r.active = req_active;
         r.can_put = req_can_put;
         r.down = req_down;
         r.weight = req_weight;
         r.left_space = req_left_space;
         r.copies = req_copies;
         r.min_space = req_min_space;
         track_request(r);
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      pick_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_picks.size() == 0) begin
            $error("unexpected response: chosen_id %0d found %0d last %0d",
                   rsp_chosen_id, rsp_found, rsp_last);
            failures++;
         end else begin
            want = pending_picks.pop_front();
            if (rsp_chosen_id !== want.chosen_id) begin
               $error("chosen_id: expected %0d, got %0d", want.chosen_id, rsp_chosen_id);
               failures++;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_found);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               failures++;
            end
         end
      end
   end

   function automatic logic [rps_pkg::SpaceWidth-1:0] rand_space();
      return rps_pkg::SpaceWidth'({$urandom, $urandom});
   endfunction

   // A request of the given kind with every field filled at random, so the
   // fields that the kind ignores still toggle.
   function automatic node_req_type any_req(rps_pkg::req_kind_type kind);
      node_req_type r;
      r.kind = kind;
      r.slot = rps_pkg::SlotWidth'($urandom);
      r.node_id = rps_pkg::IdWidth'($urandom);
      r.group_id = rps_pkg::IdWidth'($urandom);
      r.active = 1'($urandom);
      r.can_put = 1'($urandom);
      r.down = 1'($urandom);
      r.weight = rps_pkg::WeightWidth'($urandom);
      r.left_space = rand_space();
      r.copies = rps_pkg::CopiesWidth'($urandom);
      r.min_space = rand_space();
      return r;
   endfunction

   task automatic add_load(int slot, int id, int grp, bit act, bit put, bit dn, int wt);
      node_req_type r;
      r = any_req(rps_pkg::KIND_LOAD);
      r.slot = rps_pkg::SlotWidth'(slot);
      r.node_id = rps_pkg::IdWidth'(id);
      r.group_id = rps_pkg::IdWidth'(grp);
      r.active = act;
      r.can_put = put;
      r.down = dn;
      r.weight = rps_pkg::WeightWidth'(wt);
      req_backlog.insert(req_backlog.size(), r);
   endtask

   task automatic add_ping(int slot, logic [rps_pkg::SpaceWidth-1:0] space);
      node_req_type r;
      r = any_req(rps_pkg::KIND_PING);
      r.slot = rps_pkg::SlotWidth'(slot);
      r.left_space = space;
      req_backlog.insert(req_backlog.size(), r);
   endtask

   task automatic add_error(int slot);
      node_req_type r;
      r = any_req(rps_pkg::KIND_ERROR);
      r.slot = rps_pkg::SlotWidth'(slot);
      req_backlog.insert(req_backlog.size(), r);
   endtask

   task automatic add_select(int copies, logic [rps_pkg::SpaceWidth-1:0] need);
      node_req_type r;
      r = any_req(rps_pkg::KIND_SELECT);
      r.copies = rps_pkg::CopiesWidth'(copies);
      r.min_space = need;
      req_backlog.insert(req_backlog.size(), r);
   endtask

   // One well-formed round: a run of slots loaded in ascending id order,
   // pinged, a few of them hit by errors, then one or more selects. Groups
   // come from a small set so that deduplication matters, and weights are
   // often small so that ties happen. Returns the number of requests queued.
   task automatic add_round(output int added);
      int n, base, slot, wt, reps;
      logic [rps_pkg::SpaceWidth-1:0] space;
      n = $urandom_range(12, 3);
      base = $urandom_range(NodeCount - n);
      added = 0;
      for (int i = 0; i < n; i++) begin
         slot = base + i;
         wt = ($urandom_range(1)) ? $urandom_range(3) : ($urandom & 32'h7fff_ffff);
         add_load(slot, (i == 0 && $urandom_range(3) == 0) ? 0 : base * 64 + i * 97 + 1,
                  ($urandom_range(7) == 0) ? 16'hffff : $urandom_range(5),
                  $urandom_range(9) != 0, $urandom_range(9) != 0,
                  $urandom_range(9) == 0, wt);
         space = ($urandom_range(1)) ? 48'($urandom_range(1000)) : rand_space();
         add_ping(slot, space);
         added += 2;
      end
      for (int i = $urandom_range(4); i > 0; i--) begin
         slot = base + $urandom_range(n - 1);
         reps = $urandom_range(5, 1);
         for (int j = 0; j < reps; j++) add_error(slot);
         added += reps;
      end
      for (int i = $urandom_range(3, 1); i > 0; i--) begin
         case ($urandom_range(3))
            0: space = '0;
            1: space = 48'($urandom_range(1000));
            2: space = rand_space();
            default: space = '1;
         endcase
         add_select(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8, 1),
                    space);
         added++;
      end
   endtask

   task automatic add_random_phase(int target);
      int count, added;
      count = 0;
      while (count < target) begin
         if ($urandom_range(99) < 15) begin
            req_backlog.insert(req_backlog.size(),
                               any_req(rps_pkg::req_kind_type'($urandom_range(3))));
            count++;
         end else begin
            add_round(added);
            count += added;
         end
      end
   endtask

   // Waits until every queued request has gone in and every response has come
   // back, then lets a select with no response run out before going on.
   task automatic drain();
      while (req_backlog.size() != 0 || req_valid || pending_picks.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_limit(logic [rps_pkg::LimitWidth-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_error_limit <= value;
      do @(posedge clock); while (!csr_ready);
      err_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset limit of three, with no idling. Two
      // groups of extreme ids, a replaced slot, a ping and an error on empty
      // slots, a node driven down by errors and revived by a ping, and selects
      // with zero, one, all, too many and out-of-range copies.
      add_load(0, 0, 0, 1, 1, 0, 0);
      add_load(1, 1, 16'hffff, 1, 1, 0, 32'h7fff_ffff);
      add_load(2, 2, 0, 1, 1, 0, 0);
      add_load(3, 16'hffff, 7, 1, 1, 0, 5);
      add_load(4, 4, 8, 0, 1, 0, 1);
      add_ping(0, '1);
      add_ping(1, 48'd1);
      add_ping(2, '1);
      add_ping(3, 48'd100);
      add_ping(4, '1);
      add_ping(40, '1);
      add_error(41);
      add_select(0, '0);
      add_select(3, '0);
      add_select(1, 48'd99);
      add_select(4, '0);
      add_select(9, '0);
      add_select(15, '0);
      add_select(1, '1);
      for (int i = 0; i < 4; i++) add_error(3);
      add_select(3, '0);
      add_ping(3, 48'd100);
      add_load(0, 0, 9, 1, 0, 1, 0);
      add_select(3, '0);
      drain();

      // This pause with nothing in flight also serves as the full drain of
      // the pipeline the sender waits for at least once.
      write_limit(8'd0);
      set_idling(88, 0);
      add_random_phase(65);
      drain();

      write_limit(8'd255);
      set_idling(0, 88);
      add_random_phase(65);
      drain();

      write_limit(8'd1);
      set_idling(7, 7);
      add_random_phase(65);
      drain();

      write_limit(8'($urandom_range(255)));
      set_idling(0, 0);
      add_random_phase(55);
      drain();

      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Safety net well beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/rps_pkg.sv
rtl/core/rps_cell.sv
rtl/core/replica_placement_selector_top.sv
dv/tb_replica_placement_selector_top.sv
